// ===== hw/rtl/spectral_peak_frequency_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the spectral peak frequency core
// ---------------------------------------------------------------------------
`ifndef SPECTRAL_PEAK_FREQUENCY_CORE_DEFINES_SVH
`define SPECTRAL_PEAK_FREQUENCY_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define SPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/spf_pkg.sv =====
// ---------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the spectral peak frequency core.
// ---------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned RATE_W  = 18;
  localparam int unsigned LOG2_W  = 4;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned FREQ_W  = 21;
  localparam int unsigned CFG_W   = 18;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_RATE_HZ       = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FFT_LOG2      = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic [RATE_W-1:0] RESET_RATE_HZ       = 18'd44100;
  localparam logic [LOG2_W-1:0] RESET_FFT_LOG2      = 4'd10;
  localparam logic [CHAN_W-1:0] RESET_CHANNEL_COUNT = 4'd1;

  typedef struct packed {
    logic [RATE_W-1:0] rate_hz;
    logic [LOG2_W-1:0] fft_log2;
    logic [CHAN_W-1:0] channel_count;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== hw/rtl/spf_front.sv =====
// ---------------------------------------------------------------------------
// spf_front
// Accepts FFT bins, tracks the running peak and queues one job per frame.
// ---------------------------------------------------------------------------
module spf_front #(
  parameter int unsigned BIN_W = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic signed [15:0]   real_part_i,
  input  logic signed [15:0]   imag_part_i,
  input  logic                 last_bin_i,
  output logic                 push_o,
  output logic [BIN_W-1:0]     push_bin_o
);

  logic signed [31:0] sq_re;
  logic signed [31:0] sq_im;
  logic [31:0]        mag;
  logic               greater;
  logic [31:0]        best_mag_q, best_mag_d;
  logic [BIN_W-1:0]   best_bin_q, best_bin_d;
  logic [BIN_W-1:0]   cnt_q, cnt_d;

  assign sq_re   = 32'(real_part_i) * 32'(real_part_i);
  assign sq_im   = 32'(imag_part_i) * 32'(imag_part_i);
  assign mag     = 32'(sq_re) + 32'(sq_im);
  assign greater = mag > best_mag_q;

  assign push_o     = accept_i && last_bin_i;
  assign push_bin_o = greater ? cnt_q : best_bin_q;

  always_comb begin
    best_mag_d = best_mag_q;
    best_bin_d = best_bin_q;
    cnt_d      = cnt_q;
    if (accept_i) begin
      if (last_bin_i) begin
        // drop the frame state once the job is queued
        best_mag_d = '0;
        best_bin_d = '0;
        cnt_d      = '0;
      end else begin
        if (greater) begin
          best_mag_d = mag;
          best_bin_d = cnt_q;
        end
        if (cnt_q != {BIN_W{1'b1}}) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_mag_q <= '0;
      best_bin_q <= '0;
      cnt_q      <= '0;
    end else begin
      best_mag_q <= best_mag_d;
      best_bin_q <= best_bin_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/spf_fifo.sv =====
// ---------------------------------------------------------------------------
// spf_fifo
// Two-entry job queue between the peak tracker and the frequency scaler.
// ---------------------------------------------------------------------------
module spf_fifo #(
  parameter int unsigned WIDTH = 38
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     rdata_o,
  output spf_pkg::fifo_status_t status_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign rdata_o        = mem_q[rd_ptr_q];
  assign status_o.full  = count_q == CNT_W'(DEPTH);
  assign status_o.empty = count_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/spf_back.sv =====
// ---------------------------------------------------------------------------
// spf_back
// Scales the peak bin to a frequency and holds the result for the sink.
// ---------------------------------------------------------------------------
module spf_back #(
  parameter int unsigned BIN_W = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spf_pkg::fifo_status_t           status_i,
  input  logic [BIN_W-1:0]                bin_i,
  input  spf_pkg::cfg_t                   cfg_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spf_pkg::FREQ_W-1:0]      peak_frequency_o,
  output logic [BIN_W-1:0]                peak_bin_o
);

  localparam int unsigned PROD_W   = BIN_W + spf_pkg::RATE_W;
  localparam int unsigned SCALED_W = PROD_W + spf_pkg::CHAN_W;

  typedef enum logic {
    S_IDLE,
    S_SCALE
  } state_e;

  state_e                      state_q;
  logic                        out_valid_q;
  logic [spf_pkg::FREQ_W-1:0]  freq_q;
  logic [BIN_W-1:0]            bin_out_q;
  logic [PROD_W-1:0]           prod_q;
  logic [spf_pkg::LOG2_W-1:0]  shift_q;
  logic [spf_pkg::CHAN_W-1:0]  chan_q;
  logic [BIN_W-1:0]            bin_q;
  logic [PROD_W-1:0]           prod;
  logic [PROD_W-1:0]           shifted;
  logic [SCALED_W-1:0]         scaled;
  logic [spf_pkg::FREQ_W-1:0]  freq_sat;
  logic                        slot_free;

  assign pop_o     = (state_q == S_IDLE) && !status_i.empty;
  assign prod      = PROD_W'(bin_i) * PROD_W'(cfg_i.rate_hz);
  assign shifted   = prod_q >> shift_q;
  assign scaled    = SCALED_W'(shifted) * SCALED_W'(chan_q);
  assign freq_sat  = (scaled > SCALED_W'(spf_pkg::FREQ_MAX)) ?
                     spf_pkg::FREQ_MAX : scaled[spf_pkg::FREQ_W-1:0];
  assign slot_free = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign peak_frequency_o = freq_q;
  assign peak_bin_o       = bin_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      freq_q      <= '0;
      bin_out_q   <= '0;
      prod_q      <= '0;
      shift_q     <= '0;
      chan_q      <= '0;
      bin_q       <= '0;
    end else begin
      if (pop_o) begin
        prod_q  <= prod;
        shift_q <= cfg_i.fft_log2;
        chan_q  <= cfg_i.channel_count;
        bin_q   <= bin_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (!status_i.empty) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          // hold the job until the output register frees up
          if (slot_free) begin
            out_valid_q <= 1'b1;
            freq_q      <= freq_sat;
            bin_out_q   <= bin_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/spectral_peak_frequency_core.sv =====
// ---------------------------------------------------------------------------
// spectral_peak_frequency_core
// Running peak search over FFT bins, reporting peak bin and its frequency.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i / in_stall_o | real_part_i, imag_part_i, last_bin_i
//  out     | source    | out_valid_o / out_stall_i | peak_frequency_o, peak_bin_o
//  cfg     | sink      | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One bin is taken per cycle while in_stall_o is low; the peak compare runs in
// the front stage. Each last bin queues one job; the scaler multiplies as it
// pops a job, then shifts, scales and saturates into the output register, and
// pops the next job only after that. in_stall_o rises while the two-entry queue
// is full. Reset loads the default configuration and clears the frame state.
// A stalled result holds in the output register while the scaler waits.
// ---------------------------------------------------------------------------
`include "spectral_peak_frequency_core_defines.svh"

module spectral_peak_frequency_core #(
  parameter int unsigned MAX_FFT_LOG2 = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spf_pkg::CIDX_W-1:0]      cfg_index_i,
  input  logic [spf_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [15:0]              real_part_i,
  input  logic signed [15:0]              imag_part_i,
  input  logic                            last_bin_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spf_pkg::FREQ_W-1:0]      peak_frequency_o,
  output logic [MAX_FFT_LOG2-1:0]         peak_bin_o
);

  localparam int unsigned BIN_W = MAX_FFT_LOG2;
  localparam int unsigned JOB_W = BIN_W + $bits(spf_pkg::cfg_t);

  spf_pkg::cfg_t         cfg_q, cfg_d;
  spf_pkg::cfg_t         job_cfg;
  spf_pkg::fifo_status_t fifo_status;
  logic                  accept;
  logic                  push;
  logic                  pop;
  logic [BIN_W-1:0]      push_bin;
  logic [BIN_W-1:0]      job_bin;
  logic [JOB_W-1:0]      job_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        spf_pkg::CFG_RATE_HZ:
          cfg_d.rate_hz = cfg_data_i[spf_pkg::RATE_W-1:0];
        spf_pkg::CFG_FFT_LOG2:
          cfg_d.fft_log2 = cfg_data_i[spf_pkg::LOG2_W-1:0];
        spf_pkg::CFG_CHANNEL_COUNT:
          cfg_d.channel_count = cfg_data_i[spf_pkg::CHAN_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_hz       <= spf_pkg::RESET_RATE_HZ;
      cfg_q.fft_log2      <= spf_pkg::RESET_FFT_LOG2;
      cfg_q.channel_count <= spf_pkg::RESET_CHANNEL_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = fifo_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  spf_front #(
    .BIN_W (BIN_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .last_bin_i  (last_bin_i),
    .push_o      (push),
    .push_bin_o  (push_bin)
  );

  // snapshot the configuration along with each job
  spf_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  ({push_bin, cfg_q}),
    .pop_i    (pop),
    .rdata_o  (job_rdata),
    .status_o (fifo_status)
  );

  assign job_bin = job_rdata[JOB_W-1 -: BIN_W];
  assign job_cfg = job_rdata[$bits(spf_pkg::cfg_t)-1:0];

  spf_back #(
    .BIN_W (BIN_W)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .status_i         (fifo_status),
    .bin_i            (job_bin),
    .cfg_i            (job_cfg),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .peak_frequency_o (peak_frequency_o),
    .peak_bin_o       (peak_bin_o)
  );

  `SPF_ASSERT(a_push_not_full, push |-> !fifo_status.full, "job pushed into a full queue")
  `SPF_ASSERT(a_pop_not_empty, pop |-> !fifo_status.empty, "job popped from an empty queue")
  `SPF_ASSERT(a_result_after_pop, $rose(out_valid_o) |-> $past(pop, 2), "result without job")
  `SPF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule
